// File: rtl/msws_pkg.sv
package msws_pkg;

  // One input request: a raw text byte and its end flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       piece_start;
    logic       run_last;
    logic       stream_done;
    logic       malformed;
  } out_t;

  // Work handed from the decoder to the emitter for one accepted byte.
  typedef struct packed {
    logic        mark;    // emit the U+2581 marker first
    logic        start;   // piece_start on the first text byte (no marker)
    logic        done;    // last result ends the text
    logic        bad;     // text stopped on bad UTF-8
    logic [2:0]  nbytes;  // text bytes, 0..4
    logic [31:0] data;    // text bytes, first byte in the low octet
  } job_t;

  localparam logic [7:0] MARK_B0 = 8'hE2;
  localparam logic [7:0] MARK_B1 = 8'h96;
  localparam logic [7:0] MARK_B2 = 8'h81;

  localparam logic [2:0] MARK_LEN = 3'd3;

  function automatic logic [7:0] marker_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = MARK_B0;
      2'd1:    r = MARK_B1;
      default: r = MARK_B2;
    endcase
    return r;
  endfunction

  // Unicode White_Space code points.
  function automatic logic is_white(input logic [20:0] c);
    logic w;
    w = 1'b0;
    if (c >= 21'h00009 && c <= 21'h0000D) w = 1'b1;
    if (c == 21'h00020 || c == 21'h00085 || c == 21'h000A0 || c == 21'h01680) w = 1'b1;
    if (c >= 21'h02000 && c <= 21'h0200A) w = 1'b1;
    if (c == 21'h02028 || c == 21'h02029 || c == 21'h0202F) w = 1'b1;
    if (c == 21'h0205F || c == 21'h03000) w = 1'b1;
    return w;
  endfunction

endpackage

// File: rtl/msws_front.sv
module msws_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  msws_pkg::in_t  in_data,
  input  logic           skip_first,
  output logic           push,
  output msws_pkg::job_t job
);

  logic [23:0] pending_r, pending_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        inside_r, inside_nxt;
  logic        start_r, start_nxt;
  logic        stopped_r, stopped_nxt;

  logic [7:0]  b;
  logic        fin;
  logic        bad;
  logic        complete;
  logic        white;
  logic        newp;
  logic [20:0] cpv;

  assign b   = in_data.in_byte;
  assign fin = in_data.last;

  always_comb begin
    pending_nxt = pending_r;
    cp_nxt      = cp_r;
    need_nxt    = need_r;
    held_nxt    = held_r;
    inside_nxt  = inside_r;
    start_nxt   = start_r;
    stopped_nxt = stopped_r;
    bad         = 1'b0;
    complete    = 1'b0;
    white       = 1'b0;
    newp        = 1'b0;
    cpv         = cp_r;
    push        = 1'b0;
    job         = '0;

    if (accept) begin
      if (stopped_r) begin
        if (fin) begin
          pending_nxt = '0;
          cp_nxt      = '0;
          need_nxt    = '0;
          held_nxt    = '0;
          inside_nxt  = 1'b0;
          start_nxt   = 1'b1;
          stopped_nxt = 1'b0;
        end
      end else begin
        // decode
        if (need_r == 2'd0) begin
          if (b[7] == 1'b0) begin
            cpv      = {13'd0, b};
            complete = 1'b1;
          end else if ((b & 8'hE0) == 8'hC0) begin
            cp_nxt   = {16'd0, b[4:0]};
            need_nxt = 2'd1;
          end else if ((b & 8'hF0) == 8'hE0) begin
            cp_nxt   = {17'd0, b[3:0]};
            need_nxt = 2'd2;
          end else if ((b & 8'hF8) == 8'hF0) begin
            cp_nxt   = {18'd0, b[2:0]};
            need_nxt = 2'd3;
          end else begin
            bad = 1'b1;
          end
          if (!bad && !complete) begin
            pending_nxt = {16'd0, b};
            held_nxt    = 2'd1;
          end
        end else if ((b & 8'hC0) != 8'h80) begin
          bad = 1'b1;
        end else begin
          cpv = {cp_r[14:0], b[5:0]};
          if (need_r == 2'd1) begin
            complete = 1'b1;
          end else begin
            cp_nxt      = cpv;
            pending_nxt = pending_r | ({16'd0, b} << {held_r, 3'b000});
            held_nxt    = held_r + 2'd1;
            need_nxt    = need_r - 2'd1;
          end
        end

        // classify and build the job
        if (complete) begin
          white = msws_pkg::is_white(cpv);
          if (white) begin
            inside_nxt = 1'b0;
            start_nxt  = 1'b0;
          end else begin
            newp       = !inside_r;
            inside_nxt = 1'b1;
            if (newp) start_nxt = 1'b0;
            job.mark   = newp && !(skip_first && start_r);
            job.start  = newp && (skip_first && start_r);
            job.nbytes = {1'b0, held_r} + 3'd1;
            job.data   = {8'd0, pending_r} | ({24'd0, b} << {held_r, 3'b000});
            push       = 1'b1;
          end
          pending_nxt = '0;
          cp_nxt      = '0;
          need_nxt    = '0;
          held_nxt    = '0;
        end

        // truncated at end of text
        if (!bad && fin && need_nxt != 2'd0) bad = 1'b1;

        if (bad || fin) begin
          job.done    = 1'b1;
          job.bad     = bad;
          push        = 1'b1;
          pending_nxt = '0;
          cp_nxt      = '0;
          need_nxt    = '0;
          held_nxt    = '0;
          inside_nxt  = 1'b0;
          start_nxt   = 1'b1;
          stopped_nxt = !fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      cp_r      <= '0;
      need_r    <= '0;
      held_r    <= '0;
      inside_r  <= 1'b0;
      start_r   <= 1'b1;
      stopped_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      cp_r      <= cp_nxt;
      need_r    <= need_nxt;
      held_r    <= held_nxt;
      inside_r  <= inside_nxt;
      start_r   <= start_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // a bad byte always produces a request carrying the stop
  a_bad_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bad) |-> (push && job.done && job.bad))
    else $error("bad byte did not stop the text");

  // a final byte leaves the decoder at text start
  a_fin_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fin) |=> (start_r && !stopped_r && need_r == 2'd0 && !inside_r))
    else $error("decoder not cleared after final byte");

  // a held partial code point holds at least one byte, and held plus needed bytes never exceed four
  a_held_need: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r != 2'd0) |-> (held_r != 2'd0 && ({1'b0, held_r} + {1'b0, need_r}) <= 3'd4))
    else $error("held and needed byte counts disagree");

endmodule

// File: rtl/msws_queue.sv
module msws_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  msws_pkg::job_t push_job,
  input  logic           pop,
  output msws_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  msws_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("request queue count out of range");

endmodule

// File: rtl/msws_back.sv
module msws_back (
  input  logic           clk,
  input  logic           rst_n,
  input  msws_pkg::job_t job,
  input  logic           job_empty,
  output logic           job_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output msws_pkg::out_t out_data
);

  logic [2:0]     idx_r, idx_nxt;
  logic           ovalid_r, ovalid_nxt;
  msws_pkg::out_t out_r, out_nxt;

  logic [2:0] moff;
  logic [2:0] cnt;
  logic [2:0] j;
  logic       bare;
  logic       last_i;
  logic       load;
  msws_pkg::out_t res;

  assign moff   = job.mark ? msws_pkg::MARK_LEN : 3'd0;
  assign cnt    = moff + job.nbytes;
  assign bare   = (cnt == 3'd0);
  assign last_i = bare || (idx_r == cnt - 3'd1);
  assign j      = idx_r - moff;
  assign load   = !job_empty && (!ovalid_r || out_pop);

  always_comb begin
    res = '0;
    if (bare) begin
      res.out_byte   = 8'd0;
      res.byte_valid = 1'b0;
    end else if (job.mark && idx_r < msws_pkg::MARK_LEN) begin
      res.out_byte    = msws_pkg::marker_byte(idx_r[1:0]);
      res.byte_valid  = 1'b1;
      res.piece_start = (idx_r == 3'd0);
    end else begin
      res.out_byte    = job.data[{j[1:0], 3'b000} +: 8];
      res.byte_valid  = 1'b1;
      res.piece_start = job.start && (j == 3'd0);
    end
    res.run_last    = last_i;
    res.stream_done = last_i && job.done;
    res.malformed   = last_i && job.bad;
  end

  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    out_nxt    = out_r;
    job_pop    = 1'b0;
    if (load) begin
      out_nxt    = res;
      ovalid_nxt = 1'b1;
      if (last_i) begin
        idx_nxt = 3'd0;
        job_pop = 1'b1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_empty = !ovalid_r;
  assign out_data  = out_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!job_empty) |-> (idx_r <= cnt || bare))
    else $error("emit index past end of request");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (idx_r == 3'd0))
    else $error("emit index not rewound after request");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_r.stream_done) |-> out_r.run_last)
    else $error("end of text not on last result");

endmodule

// File: rtl/metaspace_word_splitter.sv
// Metaspace word splitter: UTF-8 bytes in, marked pieces out.
//
// Input queue port: in_data (byte + last flag) is taken on an edge with
// in_push high and in_full low. Result queue port: out_data is the oldest
// result while out_empty is low; it is taken on an edge with out_pop high.
// cfg_we writes cfg_data into skip_first_prefix; write it only when idle.
//
// A decoder assembles each code point, drops whitespace and turns each
// non-white code point, and each end of text or error, into one request
// (marker flag, 0..4 text bytes, end/error flags). Requests wait in a
// QDEPTH-entry queue; the emitter sends one result per cycle, while the
// receiver pops, through an output register. A byte's first result passes
// the queue slot and then the output register before it can be popped.
// The decoder takes one byte per cycle while the queue has room; the
// emitter sends up to seven results for a marked four-byte code point, so
// the emitter's result count sets the sustained rate.
// When the receiver stalls, the output register holds, the queue fills and
// in_full rises. Reset (rst_n low at an edge) empties the queue and output
// and returns the decoder to text start with skip_first_prefix cleared.
module metaspace_word_splitter #(
  parameter int QDEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  msws_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output msws_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_data
);

  logic           skip_r, skip_nxt;
  logic           accept;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  msws_pkg::job_t fj;
  msws_pkg::job_t hj;

  // config register
  assign skip_nxt = cfg_we ? cfg_data : skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
    end else begin
      skip_r <= skip_nxt;
    end
  end

  // a byte is taken whenever the queue has room for its request
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  msws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .skip_first (skip_r),
    .push       (q_push),
    .job        (fj)
  );

  msws_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (fj),
    .pop      (q_pop),
    .head_job (hj),
    .full     (q_full),
    .empty    (q_empty)
  );

  msws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (hj),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |-> !q_push)
    else $error("request created while input was refused");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!out_empty) && $past(!out_pop) && $past(rst_n)) |-> $stable(out_data))
    else $error("stalled result changed");

endmodule

// File: dv/metaspace_word_splitter_checker.sv
`timescale 1ns / 1ps

// Watches both queue ports of the splitter, predicts the piece stream for
// every accepted byte and compares each popped result in order.
module metaspace_word_splitter_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  logic           in_full,
  input  msws_pkg::in_t  in_data,
  input  logic           out_empty,
  input  logic           out_pop,
  input  msws_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_data,
  output int             error_count,
  output int             results_due,
  output int             results_checked
);

  localparam logic [7:0] METASPACE [3] = '{8'hE2, 8'h96, 8'h81};

  // predicted text state
  logic        skip_first;
  logic [23:0] held_bytes;
  logic [20:0] partial_cp;
  logic [1:0]  cont_due;
  logic [1:0]  held_cnt;
  logic        in_word;
  logic        text_start;
  logic        halted;

  msws_pkg::out_t piece_q [$];
  msws_pkg::out_t want;
  int   errors;
  int   checked;

  function automatic logic white_cp(input logic [20:0] c);
    return (c >= 21'h00009 && c <= 21'h0000D) || c == 21'h00020 || c == 21'h00085 ||
           c == 21'h000A0 || c == 21'h01680 || (c >= 21'h02000 && c <= 21'h0200A) ||
           c == 21'h02028 || c == 21'h02029 || c == 21'h0202F || c == 21'h0205F ||
           c == 21'h03000;
  endfunction

  function automatic msws_pkg::out_t text_piece(input logic [7:0] b, input logic start);
    msws_pkg::out_t r;
    r = '0;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.piece_start = start;
    return r;
  endfunction

  task automatic reset_text();
    held_bytes = '0;
    partial_cp = '0;
    cont_due   = '0;
    held_cnt   = '0;
    in_word    = 1'b0;
    text_start = 1'b1;
    halted     = 1'b0;
  endtask

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] splitter mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] g, input logic [7:0] w);
    if (g !== w)
      flag_error($sformatf("result %0d %s: got %0h, expected %0h", checked, name, g, w));
  endtask

  // Expected results for one accepted byte request.
  task automatic split_byte(input msws_pkg::in_t req);
    msws_pkg::out_t res [7];
    int         n;
    int         k;
    logic [7:0] b;
    logic       fin;
    logic       bad;
    logic       complete;
    logic       start;
    b        = req.in_byte;
    fin      = req.last;
    n        = 0;
    bad      = 1'b0;
    complete = 1'b0;
    start    = 1'b0;

    // stopped text: swallow bytes until the end flag
    if (halted) begin
      if (fin) reset_text();
      return;
    end

    if (cont_due == 2'd0) begin
      if (!b[7]) begin
        partial_cp = {13'd0, b};
        complete   = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        partial_cp = {16'd0, b[4:0]};
        cont_due   = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_cp = {17'd0, b[3:0]};
        cont_due   = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_cp = {18'd0, b[2:0]};
        cont_due   = 2'd3;
      end else begin
        bad = 1'b1;
      end
      if (cont_due != 2'd0) begin
        held_bytes = {16'd0, b};
        held_cnt   = 2'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      partial_cp = {partial_cp[14:0], b[5:0]};
      if (cont_due == 2'd1) begin
        complete = 1'b1;
      end else begin
        held_bytes = held_bytes | (24'(b) << (8 * held_cnt));
        held_cnt   = held_cnt + 2'd1;
        cont_due   = cont_due - 2'd1;
      end
    end

    if (complete) begin
      if (white_cp(partial_cp)) begin
        in_word    = 1'b0;
        text_start = 1'b0;
      end else begin
        if (!in_word) begin
          in_word = 1'b1;
          start   = 1'b1;
          if (!(skip_first && text_start)) begin
            for (k = 0; k < 3; k++) begin
              res[n] = text_piece(METASPACE[k], k == 0);
              n++;
            end
            start = 1'b0;
          end
          text_start = 1'b0;
        end
        for (k = 0; k < held_cnt; k++) begin
          res[n] = text_piece(held_bytes[8*k +: 8], start);
          n++;
          start = 1'b0;
        end
        res[n] = text_piece(b, start);
        n++;
      end
      held_bytes = '0;
      partial_cp = '0;
      cont_due   = '0;
      held_cnt   = '0;
    end

    // end flag in the middle of a code point
    if (!bad && fin && cont_due != 2'd0) bad = 1'b1;

    if (bad || fin) begin
      if (n == 0) begin
        res[0] = '0;
        n = 1;
      end
      res[n-1].stream_done = 1'b1;
      res[n-1].malformed   = bad;
      reset_text();
      if (!fin) halted = 1'b1;
    end

    if (n > 0) res[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++) piece_q.push_back(res[k]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      piece_q.delete();
      reset_text();
      skip_first = 1'b0;
    end else begin
      // a result popped now cannot come from a byte accepted now
      if (out_pop && !out_empty) begin
        checked++;
        if (piece_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: %0h",
                               checked, out_data));
        end else begin
          want = piece_q.pop_front();
          check_field("out_byte", out_data.out_byte, want.out_byte);
          check_field("byte_valid", 8'(out_data.byte_valid), 8'(want.byte_valid));
          check_field("piece_start", 8'(out_data.piece_start), 8'(want.piece_start));
          check_field("run_last", 8'(out_data.run_last), 8'(want.run_last));
          check_field("stream_done", 8'(out_data.stream_done), 8'(want.stream_done));
          check_field("malformed", 8'(out_data.malformed), 8'(want.malformed));
        end
      end
      if (cfg_we) skip_first = cfg_data;
      if (in_push && !in_full) split_byte(in_data);
    end
    error_count     <= errors;
    results_due     <= piece_q.size();
    results_checked <= checked;
  end

endmodule

// File: dv/metaspace_word_splitter_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the metaspace word splitter. The checker beside
// the block does all prediction and comparison; this module only feeds
// texts and config writes, throttles the result side and decides pass/fail.
module metaspace_word_splitter_test;

  localparam int RESET_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 300;   // long receiver stall, fills the block
  localparam int SETTLE_CYCLES  = 10;    // well past the result path through queue and output register
  // Quietest correct stretch is the long stall (HOLD_CYCLES); a random idle gap,
  // a config write and settle time are far below it. The watchdog limit is set above it.
  localparam int WATCHDOG_LIMIT = 3000;

  logic           clk      = 1'b0;
  logic           rst_n    = 1'b0;
  logic           in_push  = 1'b0;
  msws_pkg::in_t  in_data  = '0;
  logic           out_pop  = 1'b0;
  logic           cfg_we   = 1'b0;
  logic           cfg_data = 1'b0;
  logic           in_full;
  logic           out_empty;
  msws_pkg::out_t out_data;

  int error_count;
  int results_due;
  int results_checked;

  // stimulus-side bookkeeping
  logic       calm = 1'b0;      // no idling on either side once set
  int         hold_ticket = 0;  // bumped by stimulus to ask for a long stall
  int         hold_seen = 0;
  int         rx_hold = 0;
  int         rx_gap = 0;
  int         quiet = 0;
  int         sent = 0;
  logic [7:0] text_buf [$];

  always #5 clk = ~clk;

  metaspace_word_splitter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  metaspace_word_splitter_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data         (in_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  // Result side. A fresh hold_ticket starts the long stall; otherwise pop
  // runs free with random idle bursts until calm is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rx_hold != 0) begin
      out_pop <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      rx_hold   <= HOLD_CYCLES - 1;
      out_pop   <= 1'b0;
    end else if (rx_gap != 0) begin
      out_pop <= 1'b0;
      rx_gap  <= rx_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_pop <= 1'b0;
      rx_gap  <= $urandom_range(0, 15);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("metaspace_word_splitter regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Register write; only called with the block idle.
  task automatic write_skip(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Push text_buf as one text, end flag on its final byte. The push line
  // stays high across back-to-back requests and drops only for a gap.
  task automatic send_text();
    int k;
    for (k = 0; k < text_buf.size(); k++) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_push <= 1'b1;
      in_data <= {text_buf[k], k == text_buf.size() - 1};
      @(posedge clk);
      while (in_full) @(posedge clk);
      sent++;
    end
  endtask

  // Sender pause until every predicted result is out, then let any
  // zero-result request still in flight settle.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Well-formed multi-byte sequence with random payload bits; overlong
  // forms, surrogates and out-of-range values all fall out of this.
  task automatic push_code_point(input int len);
    logic [20:0] r;
    int          k;
    r = 21'($urandom);
    case (len)
      2:       text_buf.push_back({3'b110, r[4:0]});
      3:       text_buf.push_back({4'b1110, r[3:0]});
      default: text_buf.push_back({5'b11110, r[2:0]});
    endcase
    for (k = 1; k < len; k++) text_buf.push_back({2'b10, 6'($urandom)});
  endtask

  // Random texts of 1..8 code points: mostly valid words and whitespace,
  // with a broken tail (stray byte, bad continuation, truncation) now and
  // then that ends the text.
  task automatic random_part(input int target);
    int goal;
    int ncp;
    int k;
    int kind;
    int len;
    int flavor;
    goal = sent + target;
    while (sent < goal) begin
      text_buf.delete();
      ncp = $urandom_range(1, 8);
      for (k = 0; k < ncp; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          text_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else if (kind < 45) begin
          text_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end else if (kind < 65) begin
          case ($urandom_range(0, 9))
            0: text_buf.push_back(8'($urandom_range(8'h09, 8'h0D)));
            1: text_buf.push_back(8'h20);
            2: text_buf = {text_buf, 8'hC2, 8'h85};
            3: text_buf = {text_buf, 8'hC2, 8'hA0};
            4: text_buf = {text_buf, 8'hE1, 8'h9A, 8'h80};
            5: text_buf = {text_buf, 8'hE2, 8'h80, 8'(8'h80 + $urandom_range(0, 10))};
            6: text_buf = {text_buf, 8'hE2, 8'h80, 8'(8'hA8 + $urandom_range(0, 1))};
            7: text_buf = {text_buf, 8'hE2, 8'h80, 8'hAF};
            8: text_buf = {text_buf, 8'hE2, 8'h81, 8'h9F};
            default: text_buf = {text_buf, 8'hE3, 8'h80, 8'h80};
          endcase
        end else if (kind < 90) begin
          push_code_point($urandom_range(2, 4));
        end else begin
          len = $urandom_range(2, 4);
          push_code_point(len);
          flavor = $urandom_range(0, 2);
          case (flavor)
            0: begin
              // byte that can never lead
              repeat (len) void'(text_buf.pop_back());
              if ($urandom_range(0, 1))
                text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
              else
                text_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end
            1: begin
              // lead followed by a non-continuation byte
              repeat (len - 1) void'(text_buf.pop_back());
              if ($urandom_range(0, 1))
                text_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
              else
                text_buf.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end
            default: begin
              // cut short by the end flag
              repeat ($urandom_range(1, len - 1)) void'(text_buf.pop_back());
            end
          endcase
          // trailing junk after a stop is swallowed up to the end flag
          if (flavor != 2 && $urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom));
          break;
        end
      end
      send_text();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed texts, no first-piece skip
    write_skip(1'b0);
    text_buf = '{8'h00, 8'h09, 8'h7F};                     // ASCII extremes around a tab
    send_text();
    text_buf = '{8'hC2, 8'hA0, 8'hC3, 8'hA9};              // two-byte space, two-byte letter
    send_text();
    text_buf = '{8'hE2, 8'h80, 8'h83, 8'hF0, 8'h9F, 8'h98, 8'h80}; // widest piece
    send_text();
    text_buf = '{8'h20};                                   // ends with nothing to emit
    send_text();
    text_buf = '{8'hFF, 8'h42};                            // bad lead, then swallowed end
    send_text();
    text_buf = '{8'hE3, 8'h41, 8'h10};                     // bad continuation
    send_text();
    text_buf = '{8'hF4, 8'h8F};                            // truncated at the end
    send_text();
    text_buf = '{8'h80};                                   // lone continuation as final byte
    send_text();
    drain();

    // skip on, with the receiver parked for a long stretch up front
    write_skip(1'b1);
    text_buf = '{8'h61, 8'h20, 8'h62};
    send_text();
    hold_ticket <= hold_ticket + 1;
    random_part(65);
    drain();

    write_skip(1'b0);
    random_part(65);
    drain();

    // closing stretch at full rate on both sides
    write_skip(1'b1);
    calm <= 1'b1;
    random_part(60);
    drain();

    $display("run covered %0d input bytes and %0d checked results", sent, results_checked);
    $display("skip_first_prefix both ways, random idling and a %0d-cycle receiver stall",
             HOLD_CYCLES);
    if (error_count == 0 && results_due == 0) begin
      $display("metaspace_word_splitter regression: pass");
    end else begin
      $display("metaspace_word_splitter regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/msws_pkg.sv
rtl/msws_front.sv
rtl/msws_queue.sv
rtl/msws_back.sv
rtl/metaspace_word_splitter.sv
dv/metaspace_word_splitter_checker.sv
dv/metaspace_word_splitter_test.sv
